// ===== design/mqd_pkg.sv =====
// Shared types, codes and header rules for the MQTT packet deframer.
`default_nettype none

package mqd_pkg;

    // Largest fixed header: header byte plus length bytes
    localparam int unsigned MAX_HEADER_BYTES = 5;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned FLEN_W  = 29;
    localparam int unsigned ACC_W   = 28;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned PAD_W   = 3;
    localparam int unsigned OUT_W   = BYTE_W + FLEN_W + PAD_W;

    // Phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DROP  = 3'd0;
    localparam logic [STAT_W-1:0] ST_HEAD  = 3'd1;
    localparam logic [STAT_W-1:0] ST_LEN   = 3'd2;
    localparam logic [STAT_W-1:0] ST_BODY  = 3'd3;
    localparam logic [STAT_W-1:0] ST_END   = 3'd4;
    localparam logic [STAT_W-1:0] ST_ABORT = 3'd5;

    // Control packet types
    localparam logic [3:0] PKT_CONNECT     = 4'd1;
    localparam logic [3:0] PKT_CONNACK     = 4'd2;
    localparam logic [3:0] PKT_PUBLISH     = 4'd3;
    localparam logic [3:0] PKT_PUBACK      = 4'd4;
    localparam logic [3:0] PKT_PUBREC      = 4'd5;
    localparam logic [3:0] PKT_PUBREL      = 4'd6;
    localparam logic [3:0] PKT_PUBCOMP     = 4'd7;
    localparam logic [3:0] PKT_SUBSCRIBE   = 4'd8;
    localparam logic [3:0] PKT_SUBACK      = 4'd9;
    localparam logic [3:0] PKT_UNSUBSCRIBE = 4'd10;
    localparam logic [3:0] PKT_UNSUBACK    = 4'd11;
    localparam logic [3:0] PKT_PINGREQ     = 4'd12;
    localparam logic [3:0] PKT_PINGRESP    = 4'd13;
    localparam logic [3:0] PKT_DISCONNECT  = 4'd14;

    localparam logic [3:0] FLAG_PLAIN  = 4'h0;
    localparam logic [3:0] FLAG_QOS1   = 4'h2;

    typedef struct packed {
        logic [1:0]        phase;
        logic [ACC_W-1:0]  acc;
        logic [CNT_W-1:0]  cnt;
        logic [FLEN_W-1:0] seen;
        logic [FLEN_W-1:0] total;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        logic [STAT_W-1:0] status;
        logic [FLEN_W-1:0] frame_length;
    } t_result;

    localparam t_state STATE_IDLE = '0;

    function automatic logic header_ok(input logic [BYTE_W-1:0] b);
        logic [3:0] ptype;
        logic [3:0] flag;
        logic       ok;
        ptype = b[7:4];
        flag  = b[3:0];
        ok    = 1'b0;
        if (ptype == PKT_PUBLISH) begin
            ok = 1'b1;
        end else if (flag == FLAG_PLAIN) begin
            case (ptype)
                PKT_CONNECT, PKT_CONNACK, PKT_PUBACK, PKT_PUBREC, PKT_PUBCOMP,
                PKT_SUBACK, PKT_UNSUBACK, PKT_PINGREQ, PKT_PINGRESP,
                PKT_DISCONNECT: ok = 1'b1;
                default:        ok = 1'b0;
            endcase
        end else if (flag == FLAG_QOS1) begin
            case (ptype)
                PKT_PUBREL, PKT_SUBSCRIBE, PKT_UNSUBSCRIBE: ok = 1'b1;
                default:                                    ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/mqd_step.sv =====
// Per-byte framing step: next state and result from current state and byte.
`default_nettype none

module mqd_step (
    input  wire mqd_pkg::t_state               i_state,
    input  wire logic [mqd_pkg::BYTE_W-1:0]    i_byte,
    output mqd_pkg::t_state                    o_state_nxt,
    output mqd_pkg::t_result                   o_result
);

    logic [mqd_pkg::CNT_W-1:0]  cnt_inc;
    logic [mqd_pkg::FLEN_W-1:0] seen_inc;
    logic [mqd_pkg::ACC_W-1:0]  grp;
    logic [mqd_pkg::ACC_W-1:0]  grp_sh;
    logic [mqd_pkg::ACC_W-1:0]  acc_new;
    logic [mqd_pkg::FLEN_W-1:0] total_new;

    assign cnt_inc   = i_state.cnt + mqd_pkg::CNT_W'(1);
    assign seen_inc  = i_state.seen + mqd_pkg::FLEN_W'(1);
    assign grp       = mqd_pkg::ACC_W'(i_byte[mqd_pkg::GROUP_W-1:0]);
    assign acc_new   = i_state.acc | grp_sh;
    assign total_new = mqd_pkg::FLEN_W'(cnt_inc) + mqd_pkg::FLEN_W'(acc_new)
                     + mqd_pkg::FLEN_W'(1);

    // Place the 7-bit group by its position in the varint
    always_comb begin
        case (cnt_inc)
            3'd1:    grp_sh = grp;
            3'd2:    grp_sh = grp << mqd_pkg::GROUP_W;
            3'd3:    grp_sh = grp << (2 * mqd_pkg::GROUP_W);
            3'd4:    grp_sh = grp << (3 * mqd_pkg::GROUP_W);
            default: grp_sh = '0;
        endcase
    end

    always_comb begin
        o_state_nxt           = i_state;
        o_result.echo_byte    = i_byte;
        o_result.status       = mqd_pkg::ST_DROP;
        o_result.frame_length = '0;
        case (i_state.phase)
            mqd_pkg::PH_LEN: begin
                o_state_nxt.cnt  = cnt_inc;
                o_state_nxt.seen = seen_inc;
                o_state_nxt.acc  = acc_new;
                if (!i_byte[mqd_pkg::BYTE_W-1]) begin
                    o_result.frame_length = total_new;
                    if (acc_new == '0) begin
                        o_result.status = mqd_pkg::ST_END;
                        o_state_nxt     = mqd_pkg::STATE_IDLE;
                    end else begin
                        o_result.status   = mqd_pkg::ST_LEN;
                        o_state_nxt.total = total_new;
                        o_state_nxt.phase = mqd_pkg::PH_BODY;
                    end
                end else if (seen_inc >= mqd_pkg::FLEN_W'(mqd_pkg::MAX_HEADER_BYTES)) begin
                    o_result.status = mqd_pkg::ST_ABORT;
                    o_state_nxt     = mqd_pkg::STATE_IDLE;
                end else begin
                    o_result.status = mqd_pkg::ST_LEN;
                end
            end
            mqd_pkg::PH_BODY: begin
                o_state_nxt.seen      = seen_inc;
                o_result.frame_length = i_state.total;
                if (seen_inc >= i_state.total) begin
                    o_result.status = mqd_pkg::ST_END;
                    o_state_nxt     = mqd_pkg::STATE_IDLE;
                end else begin
                    o_result.status = mqd_pkg::ST_BODY;
                end
            end
            default: begin
                o_state_nxt = mqd_pkg::STATE_IDLE;
                if (mqd_pkg::header_ok(i_byte)) begin
                    o_state_nxt.phase = mqd_pkg::PH_LEN;
                    o_state_nxt.seen  = mqd_pkg::FLEN_W'(1);
                    o_result.status   = mqd_pkg::ST_HEAD;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mqtt_packet_deframer.sv =====
// Top level of the MQTT packet deframer: input register, step logic, result register.
//
//  channel  | dir | handshake               | content
//  ---------+-----+-------------------------+----------------------------------------
//  s        | in  | i_s_tvalid / o_s_tready | tdata[7:0] data_byte
//  m        | out | o_m_tvalid / i_m_tready | tdata echo_byte, frame_length; tuser status
//
// One word per cycle sustained while m accepts; an accepted word passes through the
// input register into the result register. The framing state closes its loop
// through mqd_step, which sets the rate. Synchronous active-low reset empties both
// registers and returns to idle awaiting a header. A stall on m holds the result and,
// once the input register is also full, drops o_s_tready.
`default_nettype none

module mqtt_packet_deframer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [mqd_pkg::BYTE_W-1:0]   i_s_tdata,  // [7:0] data_byte
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [mqd_pkg::OUT_W-1:0]         o_m_tdata,  // [7:0] echo_byte,
                                                          // [36:8] frame_length,
                                                          // [39:37] zero
    output logic [mqd_pkg::STAT_W-1:0]        o_m_tuser   // [2:0] status
);

    // Input register
    logic                        r_in_valid;
    logic [mqd_pkg::BYTE_W-1:0]  r_in_byte;
    // Framing state
    mqd_pkg::t_state             r_state;
    mqd_pkg::t_state             n_state;
    // Result register
    logic                        r_out_valid;
    mqd_pkg::t_result            r_out;
    mqd_pkg::t_result            n_out;

    logic advance;
    logic in_take;

    // Move the held word on whenever the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    mqd_step u_step (
        .i_state     (r_state),
        .i_byte      (r_in_byte),
        .o_state_nxt (n_state),
        .o_result    (n_out)
    );

    // Control: valid flags and framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= mqd_pkg::STATE_IDLE;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the byte and the result, hold them while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{mqd_pkg::PAD_W{1'b0}}, r_out.frame_length, r_out.echo_byte};
    assign o_m_tuser  = r_out.status;

endmodule

`default_nettype wire

// ===== design/mqd_checker.sv =====
// Port-level checks on the MQTT packet deframer, bound to its top level.
`default_nettype none

module mqd_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [mqd_pkg::OUT_W-1:0]     i_m_tdata,
    input wire logic [mqd_pkg::STAT_W-1:0]    i_m_tuser
);

    // No result may appear straight after a reset cycle
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // Only defined status codes leave the block
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser <= mqd_pkg::ST_ABORT))
        else $error("undefined status code");

    // Frame length is zero for dropped, header and abort words
    a_flen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == mqd_pkg::ST_DROP || i_m_tuser == mqd_pkg::ST_HEAD
                       || i_m_tuser == mqd_pkg::ST_ABORT)
        |-> (i_m_tdata[36:8] == '0))
        else $error("frame length set before length decoded");

    // A frame end always carries a length of at least header plus one length byte
    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == mqd_pkg::ST_END) |-> (i_m_tdata[36:8] >= 29'd2))
        else $error("frame end with short length");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tuser))
        else $error("stalled result changed");

endmodule

bind mqtt_packet_deframer mqd_checker u_mqd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);

`default_nettype wire
